// ===== rtl/fpst_pkg.sv =====
// ----------------------------------------------------------------------------
// fpst_pkg
// Shared types, constants and rule functions for the frontier path state
// transition kernel.
// ----------------------------------------------------------------------------
`default_nettype none

package fpst_pkg;

  localparam logic [3:0] MAX_GRID   = 4'd15;
  localparam logic [3:0] MIN_GRID   = 4'd2;
  localparam logic [3:0] GRID_RESET = 4'd8;
  localparam int         NUM_SUCC   = 3;

  // gap-spin patterns inserted when a pair of endpoints is created
  localparam logic [2:0] SPIN_OPEN_LO   = 3'b001;
  localparam logic [2:0] SPIN_OPEN_HI   = 3'b100;
  localparam logic [2:0] SPIN_OPEN_BOTH = 3'b101;
  // gap-spin patterns that allow a pair to be capped
  localparam logic [2:0] SPIN_CAP_MID   = 3'b010;
  localparam logic [2:0] SPIN_CAP_LO    = 3'b011;
  localparam logic [2:0] SPIN_CAP_HI    = 3'b110;
  localparam logic [1:0] SPIN_EDGE_LO   = 2'b10;
  localparam logic [1:0] SPIN_EDGE_HI   = 2'b01;

  typedef enum logic [1:0] {
    KIND_SHIFT,
    KIND_SOURCE,
    KIND_TARGET,
    KIND_CELL
  } kind_t;

  typedef struct packed {
    logic [1:0]  cnt;
    logic [15:0] v0;
    logic [15:0] v1;
  } grow_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] v;
  } drop_t;

  // bundle of successor words for one entry
  typedef struct packed {
    logic                       valid;
    logic [1:0]                 cnt;
    logic [NUM_SUCC-1:0][15:0]  sup;
    logic [NUM_SUCC-1:0][15:0]  spn;
    logic [63:0]                weight;
  } succ_set_t;

  function automatic logic [4:0] popcnt16(input logic [15:0] v);
    logic [2:0] nib [4];
    logic [4:0] c;
    for (int i = 0; i < 4; i++) begin
      nib[i] = 3'(v[4*i]) + 3'(v[4*i+1]) + 3'(v[4*i+2]) + 3'(v[4*i+3]);
    end
    c = 5'(nib[0]) + 5'(nib[1]) + 5'(nib[2]) + 5'(nib[3]);
    return c;
  endfunction

  function automatic logic [15:0] lsb_mask(input logic [3:0] k);
    return (16'd1 << k) - 16'd1;
  endfunction

  // pair creation at endpoint position r among e endpoints
  function automatic grow_t grow_pair(input logic [15:0] s, input logic [4:0] e,
                                      input logic [3:0] r);
    grow_t       res;
    logic [3:0]  g;
    logic [4:0]  sh;
    logic [15:0] lo;
    logic [15:0] hi;
    res = '0;
    g   = r - 4'd1;
    sh  = 5'(g) + 5'd3;
    lo  = s & lsb_mask(g);
    hi  = s >> (5'(g) + 5'd1);
    if (5'(r) > e) begin
      res.cnt = 2'd0;
    end else if (r == 4'd0) begin
      res.cnt = 2'd1;
      res.v0  = (s << 2) | 16'd2;
    end else if (5'(r) == e) begin
      res.cnt = 2'd1;
      res.v0  = s | (16'd1 << (e - 5'd1));
    end else if (s[g] == 1'b0) begin
      res.cnt = 2'd2;
      res.v0  = lo | (16'(SPIN_OPEN_LO) << g) | (hi << sh);
      res.v1  = lo | (16'(SPIN_OPEN_HI) << g) | (hi << sh);
    end else begin
      res.cnt = 2'd1;
      res.v0  = lo | (16'(SPIN_OPEN_BOTH) << g) | (hi << sh);
    end
    return res;
  endfunction

  // pair removal at endpoint position r among e endpoints
  function automatic drop_t drop_pair(input logic [15:0] s, input logic [4:0] e,
                                      input logic [3:0] r);
    drop_t       res;
    logic [3:0]  g;
    logic [3:0]  ge;
    logic [2:0]  t;
    logic [15:0] ta;
    logic [15:0] m;
    res = '0;
    g   = r - 4'd1;
    ge  = 4'(e - 5'd3);
    ta  = s >> g;
    t   = ta[2:0];
    m   = '0;
    if (e < 5'd3 || (5'(r) + 5'd1) >= e) begin
      res.ok = 1'b0;
    end else if (r == 4'd0) begin
      res.ok = (s[1:0] == SPIN_EDGE_LO);
      res.v  = s >> 2;
    end else if ((5'(r) + 5'd2) == e) begin
      ta     = s >> ge;
      res.ok = (ta[1:0] == SPIN_EDGE_HI);
      res.v  = s & lsb_mask(ge);
    end else begin
      if (t == SPIN_CAP_MID) begin
        res.ok = 1'b1;
        m      = 16'd0;
      end else if (t == SPIN_CAP_LO || t == SPIN_CAP_HI) begin
        res.ok = 1'b1;
        m      = 16'd1;
      end else begin
        res.ok = 1'b0;
      end
      res.v = (s & lsb_mask(g)) | (m << g) |
              ((s >> (5'(g) + 5'd3)) << (5'(g) + 5'd1));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/fpst_serial.sv =====
// ----------------------------------------------------------------------------
// fpst_serial
// Output serializer: takes a bundle of up to three successor words and puts
// them on the result ports one word per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module fpst_serial (
  input  logic              clk,
  input  logic              rst,
  input  fpst_pkg::succ_set_t set_in,
  output logic              take,
  output logic              strobe,
  output logic [15:0]       next_support,
  output logic [15:0]       next_spin,
  output logic [63:0]       out_weight,
  output logic              last
);
  import fpst_pkg::*;

  logic [1:0]                rem;
  logic [1:0]                idx;
  logic [NUM_SUCC-1:0][15:0] sup;
  logic [NUM_SUCC-1:0][15:0] spn;
  logic [63:0]               weight;

  // free now, or the last word of the held bundle goes out this cycle
  assign take = (rem == 2'd0) || (rem == 2'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      rem <= 2'd0;
      idx <= 2'd0;
    end else if (take && set_in.valid) begin
      rem <= set_in.cnt;
      idx <= 2'd0;
    end else if (rem != 2'd0) begin
      rem <= rem - 2'd1;
      idx <= idx + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (take && set_in.valid) begin
      sup    <= set_in.sup;
      spn    <= set_in.spn;
      weight <= set_in.weight;
    end
  end

  assign strobe       = (rem != 2'd0);
  assign last         = (rem == 2'd1);
  assign next_support = sup[idx];
  assign next_spin    = spn[idx];
  assign out_weight   = weight;

endmodule

`default_nettype wire

// ===== rtl/frontier_path_state_transition_top.sv =====
// ----------------------------------------------------------------------------
// frontier_path_state_transition_top
// Transition kernel of a transfer-matrix path count: one frontier entry in,
// zero to three successor entries out.
// ----------------------------------------------------------------------------
//  channel  | handshake              | payload
//  ---------+------------------------+-----------------------------------------
//  entry in | start / busy           | mode, column, row, support, spin, weight
//  config   | grid_size_we           | grid_size_wdata
//  result   | strobe (no back-press) | next_support, next_spin, out_weight, last
//
//  Three decode stages feed an output serializer, which registers each
//  bundle before its first word leaves. The single result port carries one
//  word per cycle; entries behind a bundle wait in the stages as it drains.
//  Entries with no successors vanish without using a result cycle.
//  busy rises only while the serializer still drains an earlier bundle.
//  rst (synchronous) empties the pipe and sets the grid size to 8.
// ----------------------------------------------------------------------------
`default_nettype none

module frontier_path_state_transition_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [3:0]  column,
  input  logic [3:0]  row,
  input  logic [15:0] support,
  input  logic [15:0] spin,
  input  logic [63:0] weight,
  input  logic        grid_size_we,
  input  logic [3:0]  grid_size_wdata,
  output logic        strobe,
  output logic [15:0] next_support,
  output logic [15:0] next_spin,
  output logic [63:0] out_weight,
  output logic        last
);
  import fpst_pkg::*;

  logic [3:0] grid_size;

  // pipeline control
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic ser_take;
  logic accept;

  // stage 1
  logic [3:0]  n_in;
  logic [16:0] cell_in;
  logic [4:0]  hit_cnt;
  logic [4:0]  r_cnt;
  logic [4:0]  e_cnt;
  logic [4:0]  sc_cnt;

  logic        s1_mode;
  logic [3:0]  s1_x;
  logic [3:0]  s1_y;
  logic [15:0] s1_sup;
  logic [15:0] s1_spn;
  logic [63:0] s1_w;
  logic [3:0]  s1_n;
  logic [4:0]  s1_e;
  logic [1:0]  s1_hit;
  logic [4:0]  s1_sc;
  logic [3:0]  s1_r;

  // stage 2
  kind_t       k2;
  logic [16:0] cell2;
  logic [16:0] shift_mask;
  logic [15:0] spin_hi;
  logic [4:0]  e_m1;

  kind_t       s2_kind;
  logic        s2_down;
  logic        s2_right;
  logic        s2_src_ok;
  logic        s2_tgt_ok;
  logic        s2_filt;
  logic [1:0]  s2_hit;
  logic        s2_sh_ok;
  logic [15:0] s2_shw;
  logic [15:0] s2_base;
  logic [15:0] s2_cellw;
  logic [15:0] s2_pw;
  logic [15:0] s2_qw;
  logic [15:0] s2_spn;
  grow_t       s2_grow;
  drop_t       s2_drop;
  logic [63:0] s2_w;

  // stage 3
  logic [1:0]                k;
  logic [NUM_SUCC-1:0][15:0] a_sup;
  logic [NUM_SUCC-1:0][15:0] a_spn;

  logic [1:0]                s3_cnt;
  logic [NUM_SUCC-1:0][15:0] s3_sup;
  logic [NUM_SUCC-1:0][15:0] s3_spn;
  logic [63:0]               s3_w;

  succ_set_t set3;

  assign en3    = !v3 || ser_take;
  assign en2    = !v2 || en3;
  assign en1    = !v1 || en2;
  assign busy   = !en1;
  assign accept = start && en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size <= GRID_RESET;
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
    end else begin
      if (grid_size_we) grid_size <= grid_size_wdata;
      if (en1) v1 <= start;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
  end

  // ---- stage 1: clamp grid size, count endpoints ----
  always_comb begin
    if (grid_size < MIN_GRID) n_in = MIN_GRID;
    else if (grid_size > MAX_GRID) n_in = MAX_GRID;
    else n_in = grid_size;
    cell_in = (17'd1 << column) | (17'd1 << (5'(column) + 5'd1));
    hit_cnt = popcnt16(support & cell_in[15:0]);
    r_cnt   = popcnt16(support & lsb_mask(column));
    e_cnt   = popcnt16(support);
    sc_cnt  = popcnt16(spin);
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_mode <= mode;
      s1_x    <= column;
      s1_y    <= row;
      s1_sup  <= support;
      s1_spn  <= spin;
      s1_w    <= weight;
      s1_n    <= n_in;
      s1_e    <= e_cnt;
      s1_hit  <= hit_cnt[1:0];
      s1_sc   <= sc_cnt;
      s1_r    <= r_cnt[3:0];
    end
  end

  // ---- stage 2: classify and build candidate words ----
  always_comb begin
    cell2      = (17'd1 << s1_x) | (17'd1 << (5'(s1_x) + 5'd1));
    shift_mask = (17'd1 << (5'(s1_n) + 5'd1)) - 17'd1;
    e_m1       = s1_e - 5'd1;
    spin_hi    = s1_spn >> e_m1;
    if (s1_mode) k2 = KIND_SHIFT;
    else if (s1_x == 4'd0 && s1_y == 4'd0) k2 = KIND_SOURCE;
    else if (s1_x + 4'd1 == s1_n && s1_y + 4'd1 == s1_n) k2 = KIND_TARGET;
    else k2 = KIND_CELL;
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      s2_kind   <= k2;
      s2_down   <= (5'(s1_y) + 5'd1) < 5'(s1_n);
      s2_right  <= (5'(s1_x) + 5'd1) < 5'(s1_n);
      s2_src_ok <= (s1_sup == 16'd0) && (s1_spn == 16'd0);
      s2_tgt_ok <= (s1_e == 5'd1) && (s1_hit == 2'd1);
      s2_filt   <= s1_e[0] && (s1_sc == (e_m1 >> 1)) && (spin_hi == 16'd0);
      s2_hit    <= s1_hit;
      s2_sh_ok  <= (s1_sup[s1_n] == 1'b0);
      s2_shw    <= (s1_sup << 1) & shift_mask[15:0];
      s2_base   <= s1_sup & ~cell2[15:0];
      s2_cellw  <= s1_sup | cell2[15:0];
      s2_pw     <= (s1_sup & ~cell2[15:0]) | (16'd1 << s1_x);
      s2_qw     <= (s1_sup & ~cell2[15:0]) | (16'd1 << (5'(s1_x) + 5'd1));
      s2_spn    <= s1_spn;
      s2_grow   <= grow_pair(s1_spn, s1_e, s1_r);
      s2_drop   <= drop_pair(s1_spn, s1_e, s1_r);
      s2_w      <= s1_w;
    end
  end

  // ---- stage 3: pack successors in emission order ----
  always_comb begin
    k     = 2'd0;
    a_sup = '0;
    a_spn = '0;
    case (s2_kind)
      KIND_SHIFT: begin
        if (s2_sh_ok) begin
          a_sup[k] = s2_shw;
          a_spn[k] = s2_spn;
          k        = k + 2'd1;
        end
      end
      KIND_SOURCE: begin
        if (s2_src_ok) begin
          if (s2_down) begin
            a_sup[k] = 16'd1;
            k        = k + 2'd1;
          end
          if (s2_right) begin
            a_sup[k] = 16'd2;
            k        = k + 2'd1;
          end
        end
      end
      KIND_TARGET: begin
        if (s2_tgt_ok) k = k + 2'd1;
      end
      KIND_CELL: begin
        if (s2_filt) begin
          if (s2_hit == 2'd0) begin
            a_sup[k] = s2_base;
            a_spn[k] = s2_spn;
            k        = k + 2'd1;
            if (s2_down && s2_right) begin
              if (s2_grow.cnt != 2'd0) begin
                a_sup[k] = s2_cellw;
                a_spn[k] = s2_grow.v0;
                k        = k + 2'd1;
              end
              if (s2_grow.cnt == 2'd2) begin
                a_sup[k] = s2_cellw;
                a_spn[k] = s2_grow.v1;
                k        = k + 2'd1;
              end
            end
          end else if (s2_hit == 2'd1) begin
            if (s2_down) begin
              a_sup[k] = s2_pw;
              a_spn[k] = s2_spn;
              k        = k + 2'd1;
            end
            if (s2_right) begin
              a_sup[k] = s2_qw;
              a_spn[k] = s2_spn;
              k        = k + 2'd1;
            end
          end else if (s2_drop.ok) begin
            a_sup[k] = s2_base;
            a_spn[k] = s2_drop.v;
            k        = k + 2'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3 && v2) begin
      s3_cnt <= k;
      s3_sup <= a_sup;
      s3_spn <= a_spn;
      s3_w   <= s2_w;
    end
  end

  always_comb begin
    set3.valid  = v3;
    set3.cnt    = s3_cnt;
    set3.sup    = s3_sup;
    set3.spn    = s3_spn;
    set3.weight = s3_w;
  end

  fpst_serial u_serial (
    .clk          (clk),
    .rst          (rst),
    .set_in       (set3),
    .take         (ser_take),
    .strobe       (strobe),
    .next_support (next_support),
    .next_spin    (next_spin),
    .out_weight   (out_weight),
    .last         (last)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for frontier_path_state_transition_top. Frontier entries
// are driven on the start/busy port, starting with hand-picked cell, edge and
// shift cases and then random entries across several grid sizes. A scoreboard
// predicts the successor words of every accepted entry and checks each strobed
// word against them in order.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import fpst_pkg::*;

  localparam int DRAIN_CYCLES = 12;
  localparam int QUIET_LIMIT  = 400;
  localparam int PHASE_WORDS  = 18;

  typedef struct {
    bit        mode;
    bit [3:0]  column;
    bit [3:0]  row;
    bit [15:0] support;
    bit [15:0] spin;
    bit [63:0] weight;
  } entry_t;

  typedef struct {
    bit [15:0] sup;
    bit [15:0] spn;
    bit [63:0] weight;
    bit        last;
  } succ_t;

  // predicts successor words per entry and checks them in arrival order
  class successor_board;
    bit [3:0] grid_size;
    succ_t    pending[$];
    succ_t    batch[$];
    int       errors;

    function new();
      grid_size = GRID_RESET;
      errors    = 0;
    endfunction

    function int unsigned span();
      if (grid_size < MIN_GRID) return MIN_GRID;
      if (grid_size > MAX_GRID) return MAX_GRID;
      return grid_size;
    endfunction

    function int unsigned mask_below(input int unsigned k);
      if (k >= 32) return 32'hFFFF_FFFF;
      return (32'd1 << k) - 32'd1;
    endfunction

    function void add_word(input int unsigned sup, input int unsigned spn,
                           input bit [63:0] w);
      succ_t s;
      if (batch.size() >= NUM_SUCC) return;
      s.sup    = 16'(sup);
      s.spn    = 16'(spn);
      s.weight = w;
      s.last   = 1'b0;
      batch.push_back(s);
    endfunction

    // spin words after opening a pair at endpoint position r of e
    function int pair_open(input int unsigned s, input int unsigned e,
                           input int unsigned r, output int unsigned v0,
                           output int unsigned v1);
      int unsigned g, lo, hi;
      v0 = 0;
      v1 = 0;
      if (r > e) return 0;
      if (r == 0) begin
        v0 = (s << 2) | 32'd2;
        return 1;
      end
      if (r == e) begin
        v0 = s | (32'd1 << ((e - 1) & 31));
        return 1;
      end
      g  = r - 1;
      lo = s & mask_below(g);
      hi = s >> (g + 1);
      if (((s >> g) & 1) == 0) begin
        v0 = lo | (32'(SPIN_OPEN_LO) << g) | (hi << (g + 3));
        v1 = lo | (32'(SPIN_OPEN_HI) << g) | (hi << (g + 3));
        return 2;
      end
      v0 = lo | (32'(SPIN_OPEN_BOTH) << g) | (hi << (g + 3));
      return 1;
    endfunction

    // spin word after capping a pair at endpoint position r of e
    function int pair_close(input int unsigned s, input int unsigned e,
                            input int unsigned r, output int unsigned v);
      int unsigned g, t, m;
      v = 0;
      if (e < 3 || r + 1 >= e) return 0;
      if (r == 0) begin
        if ((s & 3) != SPIN_EDGE_LO) return 0;
        v = s >> 2;
        return 1;
      end
      if (r + 2 == e) begin
        g = e - 3;
        if (((s >> g) & 3) != SPIN_EDGE_HI) return 0;
        v = s & mask_below(g);
        return 1;
      end
      g = r - 1;
      t = (s >> g) & 7;
      if (t == SPIN_CAP_MID) m = 0;
      else if (t == SPIN_CAP_LO || t == SPIN_CAP_HI) m = 1;
      else return 0;
      v = (s & mask_below(g)) | (m << g) | ((s >> (g + 3)) << (g + 1));
      return 1;
    endfunction

    function void note_entry(input entry_t it);
      int unsigned n, sup, spn, x, y, p, q, cmask, e, hit, base, r, v0, v1;
      bit          down, right;
      int          c;
      batch.delete();
      n   = span();
      sup = it.support;
      spn = it.spin;
      if (it.mode) begin
        if (((sup >> n) & 1) == 0) add_word((sup << 1) & mask_below(n + 1), spn, it.weight);
      end else begin
        x     = it.column;
        y     = it.row;
        p     = x;
        q     = x + 1;
        cmask = (32'd1 << p) | (32'd1 << q);
        down  = (y + 1 < n);
        right = (x + 1 < n);
        e     = $countones(sup);
        hit   = $countones(sup & cmask);
        if (x == 0 && y == 0) begin
          if (sup == 0 && spn == 0) begin
            if (down) add_word(32'd1 << p, 0, it.weight);
            if (right) add_word(32'd1 << q, 0, it.weight);
          end
        end else if (x + 1 == n && y + 1 == n) begin
          if (e == 1 && hit == 1) add_word(0, 0, it.weight);
        end else if ((e & 1) != 0 && $countones(spn) == (e - 1) / 2 &&
                     (spn & ~mask_below(e - 1)) == 0) begin
          base = sup & ~cmask;
          r    = $countones(sup & mask_below(p));
          if (hit == 0) begin
            add_word(base, spn, it.weight);
            if (down && right) begin
              c = pair_open(spn, e, r, v0, v1);
              if (c > 0) add_word(base | cmask, v0, it.weight);
              if (c > 1) add_word(base | cmask, v1, it.weight);
            end
          end else if (hit == 1) begin
            if (down) add_word(base | (32'd1 << p), spn, it.weight);
            if (right) add_word(base | (32'd1 << q), spn, it.weight);
          end else begin
            if (pair_close(spn, e, r, v0) > 0) add_word(base, v0, it.weight);
          end
        end
      end
      if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i]) pending.push_back(batch[i]);
    endfunction

    function void check_succ(input succ_t got);
      succ_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected word sup=%h spin=%h weight=%h last=%b",
                 $time, got.sup, got.spn, got.weight, got.last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.sup != want.sup) begin
        $display("%0t: next_support expected %h actual %h", $time, want.sup, got.sup);
        errors++;
      end
      if (got.spn != want.spn) begin
        $display("%0t: next_spin expected %h actual %h", $time, want.spn, got.spn);
        errors++;
      end
      if (got.weight != want.weight) begin
        $display("%0t: out_weight expected %h actual %h", $time, want.weight, got.weight);
        errors++;
      end
      if (got.last != want.last) begin
        $display("%0t: last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk             = 1'b0;
  logic        rst             = 1'b1;
  logic        start           = 1'b0;
  logic        busy;
  logic        mode            = 1'b0;
  logic [3:0]  column          = '0;
  logic [3:0]  row             = '0;
  logic [15:0] support         = '0;
  logic [15:0] spin            = '0;
  logic [63:0] weight          = '0;
  logic        grid_size_we    = 1'b0;
  logic [3:0]  grid_size_wdata = '0;
  logic        strobe;
  logic [15:0] next_support;
  logic [15:0] next_spin;
  logic [63:0] out_weight;
  logic        last;

  successor_board board = new();
  int             quiet_cycles = 0;

  frontier_path_state_transition_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .start           (start),
    .busy            (busy),
    .mode            (mode),
    .column          (column),
    .row             (row),
    .support         (support),
    .spin            (spin),
    .weight          (weight),
    .grid_size_we    (grid_size_we),
    .grid_size_wdata (grid_size_wdata),
    .strobe          (strobe),
    .next_support    (next_support),
    .next_spin       (next_spin),
    .out_weight      (out_weight),
    .last            (last)
  );

  always #10 clk = ~clk;

  // accept monitor, word checker and watchdog
  always @(posedge clk) begin
    entry_t it;
    succ_t  got;
    if (!rst) begin
      if (start && !busy) begin
        it.mode    = mode;
        it.column  = column;
        it.row     = row;
        it.support = support;
        it.spin    = spin;
        it.weight  = weight;
        board.note_entry(it);
      end
      if (strobe) begin
        got.sup    = next_support;
        got.spn    = next_spin;
        got.weight = out_weight;
        got.last   = last;
        board.check_succ(got);
      end
      if ((start && !busy) || strobe) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no activity for %0d cycles", $time, QUIET_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic entry_t mk(input bit md, input bit [3:0] col, input bit [3:0] rw,
                                input bit [15:0] sup, input bit [15:0] spn,
                                input bit [63:0] w);
    entry_t it;
    it.mode    = md;
    it.column  = col;
    it.row     = rw;
    it.support = sup;
    it.spin    = spn;
    it.weight  = w;
    return it;
  endfunction

  // mostly well-formed cell entries; shifts, edge cells and noise mixed in
  function automatic entry_t random_entry(input int unsigned n);
    entry_t      it;
    int unsigned pick, e, k, slot;
    it.mode    = 1'b0;
    it.column  = 4'($urandom_range(0, n - 1));
    it.row     = 4'($urandom_range(0, n - 1));
    it.support = 16'($urandom & ((32'd1 << (n + 1)) - 1));
    it.spin    = '0;
    it.weight  = {$urandom, $urandom};
    pick       = $urandom_range(0, 99);
    if (pick < 12) begin
      it.mode = 1'b1;
      it.spin = 16'($urandom);
      if (pick < 4) it.support = 16'($urandom);
    end else if (pick < 22) begin
      it.column  = 4'($urandom);
      it.row     = 4'($urandom);
      it.support = 16'($urandom);
      it.spin    = 16'($urandom);
    end else if (pick < 28) begin
      it.column  = '0;
      it.row     = '0;
      it.support = '0;
    end else if (pick < 34) begin
      it.column  = 4'(n - 1);
      it.row     = 4'(n - 1);
      it.support = 16'(32'd1 << (n - 1 + $urandom_range(0, 1)));
      if ($urandom_range(0, 3) == 0) it.support |= 16'(32'd1 << $urandom_range(0, n));
    end else begin
      // both cell slots taken steers toward pair capping
      if (pick < 60) it.support |= 16'(32'd3 << it.column);
      if ($countones(it.support) % 2 == 0) begin
        do slot = $urandom_range(0, n);
        while (pick < 60 && (slot == it.column || slot == it.column + 1));
        it.support ^= 16'(32'd1 << slot);
      end
      e = $countones(it.support);
      k = (e - 1) / 2;
      while ($countones(it.spin) < k) it.spin |= 16'(32'd1 << $urandom_range(0, e - 2));
    end
    return it;
  endfunction

  task automatic send_entry(input entry_t it);
    start   <= 1'b1;
    mode    <= it.mode;
    column  <= it.column;
    row     <= it.row;
    support <= it.support;
    spin    <= it.spin;
    weight  <= it.weight;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_gap(input int pct);
    while ($urandom_range(0, 99) < pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  // hold off until every predicted word is out, plus slack for empty entries
  task automatic wait_drained();
    start <= 1'b0;
    do @(posedge clk);
    while (board.pending.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_grid(input bit [3:0] value);
    wait_drained();
    grid_size_we    <= 1'b1;
    grid_size_wdata <= value;
    @(posedge clk);
    grid_size_we    <= 1'b0;
    board.grid_size = value;
  endtask

  initial begin
    entry_t   script[$];
    bit [3:0] grids[6];
    int       idle_pct[6];
    grids    = '{4'd15, 4'd2, 4'd0, 4'd11, 4'd1, 4'($urandom_range(3, 14))};
    idle_pct = '{25, 25, 73, 73, 0, 0};

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // grid size 8 from reset
    script.push_back(mk(0, 0, 0, 16'h0000, 16'h0000, 64'h0));
    script.push_back(mk(0, 0, 0, 16'h0001, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(0, 7, 7, 16'h0080, 16'h0000, '1));
    script.push_back(mk(0, 7, 7, 16'h0001, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(1, 0, 0, 16'h0100, 16'hFFFF, {$urandom, $urandom}));
    script.push_back(mk(1, 15, 15, 16'hFEFF, 16'hA5A5, {$urandom, $urandom}));
    script.push_back(mk(0, 3, 2, 16'h0001, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(0, 0, 3, 16'h0054, 16'h0001, {$urandom, $urandom}));
    script.push_back(mk(0, 2, 1, 16'h00A1, 16'h0002, {$urandom, $urandom}));
    script.push_back(mk(0, 2, 1, 16'h00A1, 16'h0001, {$urandom, $urandom}));
    script.push_back(mk(0, 7, 2, 16'h0080, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(0, 3, 7, 16'h0008, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(0, 3, 3, 16'h0010, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(0, 0, 2, 16'h0023, 16'h0002, {$urandom, $urandom}));
    script.push_back(mk(0, 0, 2, 16'h0023, 16'h0001, {$urandom, $urandom}));
    script.push_back(mk(0, 3, 1, 16'h0019, 16'h0001, {$urandom, $urandom}));
    script.push_back(mk(0, 3, 4, 16'h00D9, 16'h0003, {$urandom, $urandom}));
    script.push_back(mk(0, 3, 4, 16'h00D9, 16'h000A, {$urandom, $urandom}));
    script.push_back(mk(0, 3, 4, 16'h00D9, 16'h0005, {$urandom, $urandom}));
    script.push_back(mk(0, 5, 5, 16'h0003, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(0, 4, 4, 16'h0007, 16'h0003, {$urandom, $urandom}));
    script.push_back(mk(0, 4, 4, 16'h0007, 16'h0004, {$urandom, $urandom}));
    script.push_back(mk(0, 15, 3, 16'h8000, 16'h0000, {$urandom, $urandom}));
    script.push_back(mk(0, 14, 15, 16'hFFFF, 16'hFFFF, '1));
    script.push_back(mk(0, 4, 6, 16'h7FFF, 16'h1555, {$urandom, $urandom}));
    foreach (script[i]) begin
      idle_gap(25);
      send_entry(script[i]);
    end

    for (int ph = 0; ph < 6; ph++) begin
      set_grid(grids[ph]);
      for (int i = 0; i < PHASE_WORDS; i++) begin
        idle_gap(idle_pct[ph]);
        send_entry(random_entry(board.span()));
      end
    end

    wait_drained();
    if (board.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

`default_nettype wire
